// ----- hw/rtl/tawsr_pkg.sv -----
`default_nettype none
package tawsr_pkg;

	// field widths
	localparam int RATE_W  = 24;
	localparam int SPD_W   = 24;
	localparam int VOLT_W  = 16;
	localparam int SCALE_W = 16;
	localparam int MAXS_W  = 23;
	localparam int ACC_W   = 23;
	localparam int DT_W    = 20;
	localparam int DB_W    = 12;

	// shared multiplier: 24 x 23 operands, all useful products fit in 43 bits
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 23;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int PROD_W  = 43;

	// serial divider: 43-bit dividend, 23-bit divisor
	localparam int DIVR_W  = 23;
	localparam int CNT_W   = $clog2(PROD_W);

	// Q8.8 gain drops eight fraction bits
	localparam int SCALE_FRAC = 8;

	// microseconds per second
	localparam logic [DIVR_W-1:0] US_PER_S = DIVR_W'(1000000);

	// APB
	localparam int APB_DW = 32;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_SPEED_SCALE = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_SPEED   = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_VOLTAGE = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_VOLTAGE = 3'd3;
	localparam logic [IDX_W-1:0] REG_ACCEL_LIMIT = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEFAULT_DT  = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX_DT      = 3'd6;
	localparam logic [IDX_W-1:0] REG_DEADBAND    = 3'd7;

	localparam logic [SCALE_W-1:0] RST_SPEED_SCALE = 16'd256;
	localparam logic [MAXS_W-1:0]  RST_MAX_SPEED   = 23'd819200;
	localparam logic [VOLT_W-1:0]  RST_MIN_VOLTAGE = 16'd0;
	localparam logic [VOLT_W-1:0]  RST_MAX_VOLTAGE = 16'd49152;
	localparam logic [ACC_W-1:0]   RST_ACCEL_LIMIT = 23'd409600;
	localparam logic [DT_W-1:0]    RST_DEFAULT_DT  = 20'd10000;
	localparam logic [DT_W-1:0]    RST_MAX_DT      = 20'd500000;
	localparam logic [DB_W-1:0]    RST_DEADBAND    = 12'd41;

	typedef enum logic [1:0] {
		OP_RATES = 2'd0,
		OP_RAMP  = 2'd1,
		OP_STOP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MUL_RATE  = 2'd0,
		MUL_ACCEL = 2'd1,
		MUL_VOLT  = 2'd2
	} mul_sel_t;

	typedef enum logic {
		DIV_STEP = 1'b0,
		DIV_VOLT = 1'b1
	} div_sel_t;

	typedef struct packed {
		logic [SCALE_W-1:0] speed_scale;
		logic [MAXS_W-1:0]  max_speed;
		logic [VOLT_W-1:0]  min_voltage;
		logic [VOLT_W-1:0]  max_voltage;
		logic [ACC_W-1:0]   accel_limit;
		logic [DT_W-1:0]    default_dt_us;
		logic [DT_W-1:0]    max_dt_us;
		logic [DB_W-1:0]    speed_deadband;
	} cfg_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_start;
		div_sel_t div_sel;
		logic     step_ld;
		logic     tgt_wr;
		logic     whl_wr;
		logic     volt_wr;
		logic     clr;
		logic     out_ld;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic div_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/three_axis_wheel_speed_ramp_unit.sv -----
`default_nettype none
// Channel   Dir  Handshake                      Content
// s_axis    in   s_axis_tvalid / s_axis_tready  one command word, opcode in tuser
// m_axis    out  m_axis_tvalid / m_axis_tready  wheel speeds and drive voltages
// apb       in   psel, penable, pwrite, pready  eight config registers at 4*i
//
// One word at a time. Set-rates does a multiply and a target write for each of
// min(AXES,3) axes, stop clears the per-axis state, an unused opcode only finishes.
// A ramp step does one restoring divide for the step size, then one per axis for the
// voltage, all through a single shared divider and multiplier.
// A new word is taken while the previous result still waits on m_axis; the next
// result is held back until the output register frees up.
// arst_n clears the controller, the per-axis state and loads register defaults.
module three_axis_wheel_speed_ramp_unit
	import tawsr_pkg::*;
#(
	parameter int AXES = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// slave stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [95:0]       s_axis_tdata,  // roll_rate, pitch_rate, yaw_rate,
	                                              // step_time_us, 4 pad bits
	input  wire logic [1:0]        s_axis_tuser,  // opcode
	// master stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [119:0]      m_axis_tdata,  // speed_x, speed_y, speed_z,
	                                              // volt_x, volt_y, volt_z
	// config
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

	cfg_t           cfg;
	dp_cmd_t        cmd;
	dp_sts_t        sts;
	logic [AXW-1:0] ax;

	logic signed [SPD_W-1:0] speed_x, speed_y, speed_z;
	logic [VOLT_W-1:0]       volt_x, volt_y, volt_z;

	assign pready = 1'b1;

	tawsr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tawsr_ctrl #(
		.AXES (AXES),
		.AXW  (AXW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd),
		.ax        (ax)
	);

	tawsr_dp #(
		.AXES (AXES),
		.AXW  (AXW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.ax           (ax),
		.opcode       (s_axis_tuser),
		.roll_rate    ($signed(s_axis_tdata[23:0])),
		.pitch_rate   ($signed(s_axis_tdata[47:24])),
		.yaw_rate     ($signed(s_axis_tdata[71:48])),
		.step_time_us (s_axis_tdata[91:72]),
		.sts          (sts),
		.speed_x      (speed_x),
		.speed_y      (speed_y),
		.speed_z      (speed_z),
		.volt_x       (volt_x),
		.volt_y       (volt_y),
		.volt_z       (volt_z)
	);

	assign m_axis_tdata = {volt_z, volt_y, volt_x, speed_z, speed_y, speed_x};

	// one word in flight: after a take, the input side closes
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second word taken while one is in flight");

	// divider is never restarted mid-division
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	// divider only runs while a word is being worked on
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !s_axis_tready)
		else $error("divider busy while controller idle");

	// a result load always presents a word next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> m_axis_tvalid)
		else $error("result loaded but not presented");

endmodule
`default_nettype wire

// ----- hw/rtl/tawsr_regs.sv -----
`default_nettype none
module tawsr_regs
	import tawsr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output cfg_t                   cfg
);

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr;

	assign idx = paddr[ADDR_W-1:2];
	assign wr  = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_scale    <= RST_SPEED_SCALE;
			cfg_q.max_speed      <= RST_MAX_SPEED;
			cfg_q.min_voltage    <= RST_MIN_VOLTAGE;
			cfg_q.max_voltage    <= RST_MAX_VOLTAGE;
			cfg_q.accel_limit    <= RST_ACCEL_LIMIT;
			cfg_q.default_dt_us  <= RST_DEFAULT_DT;
			cfg_q.max_dt_us      <= RST_MAX_DT;
			cfg_q.speed_deadband <= RST_DEADBAND;
		end else if (wr) begin
			case (idx)
				REG_SPEED_SCALE: cfg_q.speed_scale    <= pwdata[SCALE_W-1:0];
				REG_MAX_SPEED:   cfg_q.max_speed      <= pwdata[MAXS_W-1:0];
				REG_MIN_VOLTAGE: cfg_q.min_voltage    <= pwdata[VOLT_W-1:0];
				REG_MAX_VOLTAGE: cfg_q.max_voltage    <= pwdata[VOLT_W-1:0];
				REG_ACCEL_LIMIT: cfg_q.accel_limit    <= pwdata[ACC_W-1:0];
				REG_DEFAULT_DT:  cfg_q.default_dt_us  <= pwdata[DT_W-1:0];
				REG_MAX_DT:      cfg_q.max_dt_us      <= pwdata[DT_W-1:0];
				REG_DEADBAND:    cfg_q.speed_deadband <= pwdata[DB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SPEED_SCALE: prdata = APB_DW'(cfg_q.speed_scale);
			REG_MAX_SPEED:   prdata = APB_DW'(cfg_q.max_speed);
			REG_MIN_VOLTAGE: prdata = APB_DW'(cfg_q.min_voltage);
			REG_MAX_VOLTAGE: prdata = APB_DW'(cfg_q.max_voltage);
			REG_ACCEL_LIMIT: prdata = APB_DW'(cfg_q.accel_limit);
			REG_DEFAULT_DT:  prdata = APB_DW'(cfg_q.default_dt_us);
			REG_MAX_DT:      prdata = APB_DW'(cfg_q.max_dt_us);
			REG_DEADBAND:    prdata = APB_DW'(cfg_q.speed_deadband);
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tawsr_div.sv -----
`default_nettype none
module tawsr_div
	import tawsr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PROD_W-1:0] dividend,
	input  wire logic [DIVR_W-1:0] divisor,
	output logic                   busy,
	output logic      [PROD_W-1:0] quotient
);

	// restoring divide, one quotient bit per cycle, MSB first
	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] quo_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [DIVR_W:0]   rem_sh;
	logic [DIVR_W:0]   rem_sub;
	logic              ge;

	assign rem_sh   = {rem_q, quo_q[PROD_W-1]};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign rem_sub  = rem_sh - {1'b0, dvs_q};
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(PROD_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], ge};
			rem_q <= ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tawsr_dp.sv -----
`default_nettype none
module tawsr_dp
	import tawsr_pkg::*;
#(
	parameter int AXES = 3,
	parameter int AXW  = 2
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  cfg_t                          cfg,
	input  dp_cmd_t                       cmd,
	input  wire logic [AXW-1:0]           ax,
	input  wire logic [1:0]               opcode,
	input  wire logic signed [RATE_W-1:0] roll_rate,
	input  wire logic signed [RATE_W-1:0] pitch_rate,
	input  wire logic signed [RATE_W-1:0] yaw_rate,
	input  wire logic [DT_W-1:0]          step_time_us,
	output dp_sts_t                       sts,
	output logic signed [SPD_W-1:0]       speed_x,
	output logic signed [SPD_W-1:0]       speed_y,
	output logic signed [SPD_W-1:0]       speed_z,
	output logic [VOLT_W-1:0]             volt_x,
	output logic [VOLT_W-1:0]             volt_y,
	output logic [VOLT_W-1:0]             volt_z
);

	localparam int TGT_W = PROD_W - SCALE_FRAC;

	// per-axis state
	logic signed [SPD_W-1:0] tgt_q [AXES];
	logic signed [SPD_W-1:0] whl_q [AXES];
	logic [VOLT_W-1:0]       vlt_q [AXES];

	// captured word and working registers
	op_t                      op_q;
	logic signed [RATE_W-1:0] rate_q [3];
	logic [DT_W-1:0]          dt_q;
	logic [PROD_W-1:0]        prod_q;
	logic [SPD_W-1:0]         step_q;
	logic signed [SPD_W-1:0]  spd_o_q [3];
	logic [VOLT_W-1:0]        vlt_o_q [3];

	logic [2:0]               ax3;
	logic signed [RATE_W-1:0] rate_cur;
	logic                     rate_neg;
	logic [MUL_A_W-1:0]       rate_mag;
	logic [DT_W-1:0]          dt_eff;
	logic signed [VOLT_W:0]   span;
	logic [VOLT_W-1:0]        span_mag;
	logic signed [SPD_W-1:0]  tgt_cur;
	logic signed [SPD_W-1:0]  whl_cur;
	logic [SPD_W-1:0]         whl_mag;
	logic [MUL_A_W-1:0]       mul_a;
	logic [MUL_B_W-1:0]       mul_b;
	logic [MUL_P_W-1:0]       mul_full;
	logic [TGT_W-1:0]         t_scaled;
	logic [MAXS_W-1:0]        t_mag;
	logic signed [SPD_W-1:0]  tgt_new;
	logic signed [SPD_W:0]    diff;
	logic signed [SPD_W:0]    stp;
	logic signed [SPD_W:0]    d_lim;
	logic signed [SPD_W-1:0]  whl_new;
	logic [VOLT_W-1:0]        quo_v;
	logic [VOLT_W-1:0]        v_interp;
	logic [VOLT_W-1:0]        vol_new;
	logic [DIVR_W-1:0]        div_dvs;
	logic [PROD_W-1:0]        quo;
	logic                     div_busy;
	logic signed [SPD_W-1:0]  spd_view [3];
	logic [VOLT_W-1:0]        vlt_view [3];

	assign ax3 = 3'(ax);

	always_comb begin
		case (ax3)
			3'd0:    rate_cur = rate_q[0];
			3'd1:    rate_cur = rate_q[1];
			default: rate_cur = rate_q[2];
		endcase
	end

	assign rate_neg = rate_cur[RATE_W-1];
	assign rate_mag = rate_neg ? MUL_A_W'(-rate_cur) : MUL_A_W'(rate_cur);

	// zero or out-of-range dt falls back to the default
	assign dt_eff = (dt_q == '0 || dt_q > cfg.max_dt_us) ? cfg.default_dt_us : dt_q;

	assign span     = $signed({1'b0, cfg.max_voltage}) - $signed({1'b0, cfg.min_voltage});
	assign span_mag = span[VOLT_W] ? VOLT_W'(-span) : span[VOLT_W-1:0];

	assign tgt_cur = tgt_q[ax];
	assign whl_cur = whl_q[ax];
	assign whl_mag = whl_cur[SPD_W-1] ? SPD_W'(-whl_cur) : SPD_W'(whl_cur);

	always_comb begin
		case (cmd.mul_sel)
			MUL_RATE: begin
				mul_a = rate_mag;
				mul_b = MUL_B_W'(cfg.speed_scale);
			end
			MUL_ACCEL: begin
				mul_a = MUL_A_W'(dt_eff);
				mul_b = cfg.accel_limit;
			end
			MUL_VOLT: begin
				mul_a = whl_mag;
				mul_b = MUL_B_W'(span_mag);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

	// target: clamp scaled magnitude, wheel spins against the body rate
	assign t_scaled = prod_q[PROD_W-1:SCALE_FRAC];
	assign t_mag    = (t_scaled > TGT_W'(cfg.max_speed)) ? cfg.max_speed
	                                                      : t_scaled[MAXS_W-1:0];
	assign tgt_new  = rate_neg ? $signed({1'b0, t_mag}) : -$signed({1'b0, t_mag});

	// slew limit
	assign diff = $signed({tgt_cur[SPD_W-1], tgt_cur}) - $signed({whl_cur[SPD_W-1], whl_cur});
	assign stp  = $signed({1'b0, step_q});

	always_comb begin
		if (diff > stp)
			d_lim = stp;
		else if (diff < -stp)
			d_lim = -stp;
		else
			d_lim = diff;
	end

	assign whl_new = SPD_W'(whl_cur + $signed(d_lim[SPD_W-1:0]));

	// drive voltage
	assign quo_v    = quo[VOLT_W-1:0];
	assign v_interp = span[VOLT_W] ? cfg.min_voltage - quo_v : cfg.min_voltage + quo_v;

	always_comb begin
		if (whl_mag < SPD_W'(cfg.speed_deadband))
			vol_new = '0;
		else if (cfg.max_speed == '0 || whl_mag >= SPD_W'(cfg.max_speed))
			vol_new = cfg.max_voltage;
		else
			vol_new = v_interp;
	end

	assign div_dvs = (cmd.div_sel == DIV_STEP) ? US_PER_S : cfg.max_speed;

	tawsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign sts.op       = op_q;
	assign sts.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				tgt_q[i] <= '0;
				whl_q[i] <= '0;
				vlt_q[i] <= '0;
			end
		end else if (cmd.clr) begin
			for (int i = 0; i < AXES; i++) begin
				tgt_q[i] <= '0;
				whl_q[i] <= '0;
				vlt_q[i] <= '0;
			end
		end else begin
			if (cmd.tgt_wr)
				tgt_q[ax] <= tgt_new;
			if (cmd.whl_wr)
				whl_q[ax] <= whl_new;
			if (cmd.volt_wr)
				vlt_q[ax] <= vol_new;
		end
	end

	// missing axes report zero
	for (genvar g = 0; g < 3; g++) begin : g_view
		if (g < AXES) begin : g_on
			assign spd_view[g] = whl_q[g];
			assign vlt_view[g] = vlt_q[g];
		end else begin : g_off
			assign spd_view[g] = '0;
			assign vlt_view[g] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q      <= op_t'(opcode);
			rate_q[0] <= roll_rate;
			rate_q[1] <= pitch_rate;
			rate_q[2] <= yaw_rate;
			dt_q      <= step_time_us;
		end
		if (cmd.mul_en)
			prod_q <= mul_full[PROD_W-1:0];
		if (cmd.step_ld)
			step_q <= quo[SPD_W-1:0];
		if (cmd.out_ld) begin
			for (int k = 0; k < 3; k++) begin
				spd_o_q[k] <= spd_view[k];
				vlt_o_q[k] <= vlt_view[k];
			end
		end
	end

	assign speed_x = spd_o_q[0];
	assign speed_y = spd_o_q[1];
	assign speed_z = spd_o_q[2];
	assign volt_x  = vlt_o_q[0];
	assign volt_y  = vlt_o_q[1];
	assign volt_z  = vlt_o_q[2];

endmodule
`default_nettype wire

// ----- hw/rtl/tawsr_ctrl.sv -----
`default_nettype none
module tawsr_ctrl
	import tawsr_pkg::*;
#(
	parameter int AXES = 3,
	parameter int AXW  = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  dp_sts_t             sts,
	output dp_cmd_t             cmd,
	output logic      [AXW-1:0] ax
);

	localparam int RATE_AXES = (AXES < 3) ? AXES : 3;
	localparam logic [AXW-1:0] RATE_LAST = AXW'(RATE_AXES - 1);
	localparam logic [AXW-1:0] AX_LAST   = AXW'(AXES - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_RMUL,
		S_RTGT,
		S_SMUL,
		S_SDIV,
		S_SWAIT,
		S_UPD,
		S_VMUL,
		S_VDIV,
		S_VWAIT,
		S_VWR,
		S_CLR,
		S_FIN
	} state_t;

	state_t         state_q;
	logic [AXW-1:0] ax_q;
	logic           out_valid_q;
	logic           out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign ax        = ax_q;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_RATE;
		cmd.div_sel = DIV_STEP;
		case (state_q)
			S_IDLE:  cmd.load_in = in_valid;
			S_RMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RATE;
			end
			S_RTGT:  cmd.tgt_wr = 1'b1;
			S_SMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ACCEL;
			end
			S_SDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_STEP;
			end
			S_SWAIT: cmd.step_ld = !sts.div_busy;
			S_UPD:   cmd.whl_wr = 1'b1;
			S_VMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_VOLT;
			end
			S_VDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_VOLT;
			end
			S_VWR:   cmd.volt_wr = 1'b1;
			S_CLR:   cmd.clr = 1'b1;
			S_FIN:   cmd.out_ld = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DEC;
				end
				S_DEC: begin
					ax_q <= '0;
					case (sts.op)
						OP_RATES: state_q <= S_RMUL;
						OP_RAMP:  state_q <= S_SMUL;
						OP_STOP:  state_q <= S_CLR;
						default:  state_q <= S_FIN;
					endcase
				end
				S_RMUL: state_q <= S_RTGT;
				S_RTGT: begin
					if (ax_q == RATE_LAST) begin
						state_q <= S_FIN;
					end else begin
						ax_q    <= ax_q + AXW'(1);
						state_q <= S_RMUL;
					end
				end
				S_SMUL: state_q <= S_SDIV;
				S_SDIV: state_q <= S_SWAIT;
				S_SWAIT: begin
					if (!sts.div_busy)
						state_q <= S_UPD;
				end
				S_UPD:  state_q <= S_VMUL;
				S_VMUL: state_q <= S_VDIV;
				S_VDIV: state_q <= S_VWAIT;
				S_VWAIT: begin
					if (!sts.div_busy)
						state_q <= S_VWR;
				end
				S_VWR: begin
					if (ax_q == AX_LAST) begin
						state_q <= S_FIN;
					end else begin
						ax_q    <= ax_q + AXW'(1);
						state_q <= S_UPD;
					end
				end
				S_CLR: state_q <= S_FIN;
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
